FILE: src/gsa_pkg.sv
package gsa_pkg;

    localparam int SLOT_BITS  = 10;
    localparam int GEN_BITS   = 16;
    localparam int REF_BITS   = 32;
    localparam int CNT_BITS   = SLOT_BITS + 1;
    localparam int SLOT_COUNT = 2 ** SLOT_BITS;

    // empty-list sentinel and pool size, one bit wider than a slot
    localparam logic [CNT_BITS-1:0] NSLOTS = {1'b1, {SLOT_BITS{1'b0}}};

    // request codes; code three acts as a lookup
    localparam logic [1:0] REQ_ALLOC  = 2'd0;
    localparam logic [1:0] REQ_FREE   = 2'd1;
    localparam logic [1:0] REQ_LOOKUP = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [1:0] ST_NOT_ALIVE = 2'd2;

    // one slot entry as kept in the slot RAM
    typedef struct packed {
        logic                alive;
        logic [GEN_BITS-1:0] gen;
        logic [REF_BITS-1:0] ref_word;
        logic [CNT_BITS-1:0] link;
    } t_entry;

    localparam int ENTRY_BITS = $bits(t_entry);

endpackage

FILE: src/gsa_req_if.sv
interface gsa_req_if;
    import gsa_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [1:0]           req_type;
    logic [SLOT_BITS-1:0] slot_index;
    logic [GEN_BITS-1:0]  handle_generation;
    logic [REF_BITS-1:0]  ref_word;

    modport source (output valid, req_type, slot_index, handle_generation, ref_word,
                    input ready);
    modport sink   (input valid, req_type, slot_index, handle_generation, ref_word,
                    output ready);
endinterface

FILE: src/gsa_rsp_if.sv
interface gsa_rsp_if;
    import gsa_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [1:0]           status;
    logic [SLOT_BITS-1:0] out_slot;
    logic [GEN_BITS-1:0]  out_generation;
    logic                 is_alive;
    logic [REF_BITS-1:0]  out_ref;
    logic [CNT_BITS-1:0]  live_total;

    modport source (output valid, status, out_slot, out_generation, is_alive, out_ref,
                    live_total, input ready);
    modport sink   (input valid, status, out_slot, out_generation, is_alive, out_ref,
                    live_total, output ready);
endinterface

FILE: src/generational_slot_allocator_top.sv
// Channel  Dir  Modport            Beat contents
// i_req    in   gsa_req_if.sink    req_type, slot_index, handle_generation, ref_word
// o_rsp    out  gsa_rsp_if.source  status, out_slot, out_generation, is_alive,
//                                  out_ref, live_total
//
// Each request passes through two states: the accept in S_IDLE reads the slot RAM,
// and S_EVAL evaluates the entry and writes it back through the same RAM port pair.
// The result sits in an output register; a new request is taken while it waits,
// and evaluation holds only if the previous result has not yet been taken.
// Reset (synchronous, active low) empties the free list and clears the
// high-water mark and live count; slots at or above the mark read as never used.
module generational_slot_allocator_top (
    input  logic             i_clk,
    input  logic             i_rst_n,
    gsa_req_if.sink          i_req,
    gsa_rsp_if.source        o_rsp
);
    import gsa_pkg::*;

    typedef enum logic {S_IDLE, S_EVAL} t_state;

    t_state               r_state, n_state;
    logic [CNT_BITS-1:0]  r_free_top, n_free_top;
    logic [CNT_BITS-1:0]  r_high_mark, n_high_mark;
    logic [CNT_BITS-1:0]  r_live, n_live;

    // latched request
    logic [1:0]           r_req_type, n_req_type;
    logic [SLOT_BITS-1:0] r_slot, n_slot;
    logic [GEN_BITS-1:0]  r_gen, n_gen;
    logic [REF_BITS-1:0]  r_word, n_word;

    // output register
    logic                 r_out_valid, n_out_valid;
    logic [1:0]           r_status, n_status;
    logic [SLOT_BITS-1:0] r_out_slot, n_out_slot;
    logic [GEN_BITS-1:0]  r_out_gen, n_out_gen;
    logic                 r_out_alive, n_out_alive;
    logic [REF_BITS-1:0]  r_out_ref, n_out_ref;

    logic                 w_accept;
    logic                 w_rd_en;
    logic [SLOT_BITS-1:0] w_rd_addr;
    logic                 w_wr_en;
    logic [SLOT_BITS-1:0] w_wr_addr;
    t_entry               w_wr_entry;
    t_entry               w_rd_entry;
    logic [ENTRY_BITS-1:0] w_rd_data;
    logic                 w_out_free;
    logic                 w_handle_live;

    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;

    // read the head of the free list on allocate, the named slot otherwise
    assign w_rd_en   = w_accept;
    assign w_rd_addr = (i_req.req_type == REQ_ALLOC) ? r_free_top[SLOT_BITS-1:0]
                                                     : i_req.slot_index;

    gsa_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (SLOT_COUNT)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_wr_en),
        .i_waddr (w_wr_addr),
        .i_wdata (w_wr_entry),
        .i_re    (w_rd_en),
        .i_raddr (w_rd_addr),
        .o_rdata (w_rd_data)
    );

    assign w_rd_entry = t_entry'(w_rd_data);
    assign w_out_free = !r_out_valid || o_rsp.ready;

    // slots at or above the mark were never handed out
    assign w_handle_live = ({1'b0, r_slot} < r_high_mark) && w_rd_entry.alive
                           && (w_rd_entry.gen == r_gen);

    // sequence one request: latch, evaluate, write back, load result
    always_comb begin
        n_state     = r_state;
        n_free_top  = r_free_top;
        n_high_mark = r_high_mark;
        n_live      = r_live;
        n_req_type  = r_req_type;
        n_slot      = r_slot;
        n_gen       = r_gen;
        n_word      = r_word;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_status    = r_status;
        n_out_slot  = r_out_slot;
        n_out_gen   = r_out_gen;
        n_out_alive = r_out_alive;
        n_out_ref   = r_out_ref;
        w_wr_en     = 1'b0;
        w_wr_addr   = r_slot;
        w_wr_entry  = w_rd_entry;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_req_type = i_req.req_type;
                    n_slot     = i_req.slot_index;
                    n_gen      = i_req.handle_generation;
                    n_word     = i_req.ref_word;
                    n_state    = S_EVAL;
                end
            end
            S_EVAL: begin
                if (w_out_free) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    n_status    = ST_OK;
                    n_out_slot  = r_slot;
                    n_out_gen   = '0;
                    n_out_alive = 1'b0;
                    n_out_ref   = '0;
                    case (r_req_type)
                        REQ_ALLOC: begin
                            if (r_free_top < NSLOTS) begin
                                // pop the free list
                                w_wr_en             = 1'b1;
                                w_wr_addr           = r_free_top[SLOT_BITS-1:0];
                                w_wr_entry.alive    = 1'b1;
                                w_wr_entry.ref_word = r_word;
                                n_free_top  = (w_rd_entry.link > NSLOTS) ? NSLOTS
                                                                         : w_rd_entry.link;
                                n_live      = r_live + CNT_BITS'(1);
                                n_out_slot  = r_free_top[SLOT_BITS-1:0];
                                n_out_gen   = w_rd_entry.gen;
                                n_out_alive = 1'b1;
                            end else if (r_high_mark < NSLOTS) begin
                                // take a fresh slot at generation zero
                                w_wr_en             = 1'b1;
                                w_wr_addr           = r_high_mark[SLOT_BITS-1:0];
                                w_wr_entry.alive    = 1'b1;
                                w_wr_entry.gen      = '0;
                                w_wr_entry.ref_word = r_word;
                                w_wr_entry.link     = '0;
                                n_high_mark = r_high_mark + CNT_BITS'(1);
                                n_live      = r_live + CNT_BITS'(1);
                                n_out_slot  = r_high_mark[SLOT_BITS-1:0];
                                n_out_alive = 1'b1;
                            end else begin
                                n_status   = ST_EXHAUSTED;
                                n_out_slot = '0;
                            end
                        end
                        REQ_FREE: begin
                            if (w_handle_live) begin
                                // retire the handle and push the slot
                                w_wr_en          = 1'b1;
                                w_wr_entry.alive = 1'b0;
                                w_wr_entry.gen   = w_rd_entry.gen + GEN_BITS'(1);
                                w_wr_entry.link  = r_free_top;
                                n_free_top = {1'b0, r_slot};
                                n_live     = r_live - CNT_BITS'(1);
                                n_out_gen  = w_rd_entry.gen + GEN_BITS'(1);
                            end else begin
                                n_status = ST_NOT_ALIVE;
                            end
                        end
                        default: begin
                            if (w_handle_live) begin
                                n_out_gen   = w_rd_entry.gen;
                                n_out_alive = 1'b1;
                                n_out_ref   = w_rd_entry.ref_word;
                            end else begin
                                n_status = ST_NOT_ALIVE;
                            end
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // hold state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_free_top  <= NSLOTS;
            r_high_mark <= '0;
            r_live      <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_free_top  <= n_free_top;
            r_high_mark <= n_high_mark;
            r_live      <= n_live;
        end
        r_req_type  <= n_req_type;
        r_slot      <= n_slot;
        r_gen       <= n_gen;
        r_word      <= n_word;
        r_status    <= n_status;
        r_out_slot  <= n_out_slot;
        r_out_gen   <= n_out_gen;
        r_out_alive <= n_out_alive;
        r_out_ref   <= n_out_ref;
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.status         = r_status;
    assign o_rsp.out_slot       = r_out_slot;
    assign o_rsp.out_generation = r_out_gen;
    assign o_rsp.is_alive       = r_out_alive;
    assign o_rsp.out_ref        = r_out_ref;
    assign o_rsp.live_total     = r_live;

endmodule

FILE: src/gsa_ram.sv
module gsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write one entry, register the read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: verif/tb_top.sv
module tb_top;
    import gsa_pkg::*;

    // spare request code, decoded by the block as a lookup
    localparam logic [1:0] REQ_SPARE = 2'd3;
    localparam int STALL_LIMIT = 1000;
    localparam int RANDOM_ITEMS = 640;
    localparam int REUSE_ROUNDS = 16;

    typedef struct packed {
        logic [1:0]           kind;
        logic [SLOT_BITS-1:0] slot;
        logic [GEN_BITS-1:0]  gen;
        logic [REF_BITS-1:0]  word;
    } t_req_beat;

    typedef struct packed {
        logic [1:0]           status;
        logic [SLOT_BITS-1:0] slot;
        logic [GEN_BITS-1:0]  gen;
        logic                 alive;
        logic [REF_BITS-1:0]  word;
        logic [CNT_BITS-1:0]  live;
    } t_rsp_beat;

    logic i_clk;
    logic i_rst_n;

    gsa_req_if req_if ();
    gsa_rsp_if rsp_if ();

    generational_slot_allocator_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // shadow of the slot pool
    logic                 slot_alive [SLOT_COUNT];
    logic [GEN_BITS-1:0]  slot_gen   [SLOT_COUNT];
    logic [CNT_BITS-1:0]  slot_link  [SLOT_COUNT];
    logic [REF_BITS-1:0]  slot_ref   [SLOT_COUNT];
    logic [CNT_BITS-1:0]  free_head;
    logic [CNT_BITS-1:0]  high_water;
    logic [CNT_BITS-1:0]  live_cnt;

    t_rsp_beat pending_results [$];
    int        mismatch_count;
    bit        steady;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit stall_now();
        return !steady && ($urandom_range(99) < 8);
    endfunction

    function automatic bit handle_live(logic [SLOT_BITS-1:0] s, logic [GEN_BITS-1:0] g);
        return ({1'b0, s} < high_water) && slot_alive[s] && (slot_gen[s] == g);
    endfunction

    // advance the shadow pool by one request and return the result it yields
    function automatic t_rsp_beat allocator_step(t_req_beat b);
        t_rsp_beat            r;
        logic [SLOT_BITS-1:0] s;
        r = '0;
        case (b.kind)
            REQ_ALLOC: begin
                if (free_head != NSLOTS || high_water != NSLOTS) begin
                    // pop the free list first, then take a fresh slot
                    if (free_head != NSLOTS) begin
                        s = free_head[SLOT_BITS-1:0];
                        free_head = slot_link[s];
                    end else begin
                        s = high_water[SLOT_BITS-1:0];
                        high_water = high_water + 1'b1;
                    end
                    slot_alive[s] = 1'b1;
                    slot_ref[s] = b.word;
                    live_cnt = live_cnt + 1'b1;
                    r.slot = s;
                    r.gen = slot_gen[s];
                    r.alive = 1'b1;
                end else begin
                    r.status = ST_EXHAUSTED;
                end
            end
            REQ_FREE: begin
                r.slot = b.slot;
                if (handle_live(b.slot, b.gen)) begin
                    slot_alive[b.slot] = 1'b0;
                    slot_gen[b.slot] = slot_gen[b.slot] + 1'b1;
                    slot_link[b.slot] = free_head;
                    free_head = {1'b0, b.slot};
                    live_cnt = live_cnt - 1'b1;
                    r.gen = slot_gen[b.slot];
                end else begin
                    r.status = ST_NOT_ALIVE;
                end
            end
            default: begin
                r.slot = b.slot;
                if (handle_live(b.slot, b.gen)) begin
                    r.gen = slot_gen[b.slot];
                    r.alive = 1'b1;
                    r.word = slot_ref[b.slot];
                end else begin
                    r.status = ST_NOT_ALIVE;
                end
            end
        endcase
        r.live = live_cnt;
        return r;
    endfunction

    // drive one request beat; entered and left at a falling edge
    task automatic send_req(logic [1:0] kind, logic [SLOT_BITS-1:0] slot,
                            logic [GEN_BITS-1:0] gen, logic [REF_BITS-1:0] word);
        t_req_beat b;
        t_rsp_beat due_beat;
        b = '{kind: kind, slot: slot, gen: gen, word: word};
        while (stall_now()) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid             <= 1'b1;
        req_if.req_type          <= kind;
        req_if.slot_index        <= slot;
        req_if.handle_generation <= gen;
        req_if.ref_word          <= word;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        due_beat = allocator_step(b);
        pending_results = {pending_results, due_beat};
        @(negedge i_clk);
    endtask

    function automatic bit pick_live_slot(output logic [SLOT_BITS-1:0] s);
        int start;
        int k;
        s = '0;
        if (live_cnt == 0) return 0;
        start = $urandom_range(int'(high_water) - 1);
        for (k = 0; k < int'(high_water); k++) begin
            s = SLOT_BITS'((start + k) % int'(high_water));
            if (slot_alive[s]) return 1;
        end
        return 0;
    endfunction

    // mostly live handles, some off by one generation, some stale, some noise
    function automatic void pick_handle(output logic [SLOT_BITS-1:0] s,
                                        output logic [GEN_BITS-1:0] g);
        int r;
        r = $urandom_range(9);
        if (r < 8 && pick_live_slot(s)) begin
            g = slot_gen[s];
            if (r == 7) g = $urandom_range(1) ? g + 1'b1 : g - 1'b1;
        end else if (r == 8 && high_water != 0) begin
            s = SLOT_BITS'($urandom_range(int'(high_water) - 1));
            g = slot_gen[s];
        end else begin
            s = SLOT_BITS'($urandom);
            g = GEN_BITS'($urandom);
        end
    endfunction

    function automatic void check_field(string name, longint unsigned want,
                                        longint unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    // take each result beat and compare with the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_rsp_beat due;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_results.size() == 0) begin
                $error("result beat with nothing outstanding: slot %0d", rsp_if.out_slot);
                mismatch_count++;
            end else begin
                due = pending_results.pop_front();
                check_field("status", due.status, rsp_if.status);
                check_field("out_slot", due.slot, rsp_if.out_slot);
                check_field("out_generation", due.gen, rsp_if.out_generation);
                check_field("is_alive", due.alive, rsp_if.is_alive);
                check_field("out_ref", due.word, rsp_if.out_ref);
                check_field("live_total", due.live, rsp_if.live_total);
            end
        end
    end

    // stall the result side at random
    always @(negedge i_clk) begin
        rsp_if.ready <= !stall_now();
    end

    // end the run when nothing moves for too long
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("** generational_slot_allocator_top: FAILED **");
        $finish;
    end

    // handles against an empty pool are all dead
    task automatic test_empty_pool();
        send_req(REQ_LOOKUP, '0, '0, '0);
        send_req(REQ_LOOKUP, '1, '1, '1);
        send_req(REQ_FREE, '0, '0, '0);
    endtask

    // allocate, resolve, free, and reuse slots in LIFO order
    task automatic test_handle_lifecycle();
        send_req(REQ_ALLOC, '0, '0, '0);
        send_req(REQ_ALLOC, '1, '1, '1);
        send_req(REQ_ALLOC, '0, '0, 32'ha5a5_5a5a);
        send_req(REQ_LOOKUP, 10'd0, '0, '0);
        send_req(REQ_LOOKUP, 10'd1, '0, '0);
        send_req(REQ_SPARE, 10'd2, '0, '0);
        send_req(REQ_LOOKUP, 10'd1, '1, '0);
        // slot at the high-water mark
        send_req(REQ_LOOKUP, 10'd3, '0, '0);
        send_req(REQ_FREE, 10'd1, '0, '0);
        // double free and stale lookup
        send_req(REQ_FREE, 10'd1, '0, '0);
        send_req(REQ_LOOKUP, 10'd1, 16'd1, '0);
        send_req(REQ_FREE, 10'd0, '0, '0);
        send_req(REQ_FREE, 10'd2, '0, '0);
        // pops come back newest first, then the high-water slot
        repeat (4) send_req(REQ_ALLOC, '1, '1, $urandom);
        send_req(REQ_LOOKUP, 10'd1, 16'd1, '0);
        send_req(REQ_FREE, '1, '1, '0);
    endtask

    task automatic test_random_traffic(int count);
        int                   n;
        int                   r;
        logic [SLOT_BITS-1:0] s;
        logic [GEN_BITS-1:0]  g;
        logic [REF_BITS-1:0]  w;
        for (n = 0; n < count; n++) begin
            // hold a stretch with no stalls on either side
            steady = (n >= count / 3) && (n < count / 2);
            r = $urandom_range(99);
            pick_handle(s, g);
            if (r < 38) begin
                case ($urandom_range(15))
                    0:       w = '0;
                    1:       w = '1;
                    default: w = $urandom;
                endcase
                send_req(REQ_ALLOC, s, g, w);
            end else if (r < 68) begin
                send_req(REQ_FREE, s, g, $urandom);
            end else if (r < 95) begin
                send_req(REQ_LOOKUP, s, g, $urandom);
            end else begin
                send_req(REQ_SPARE, s, g, $urandom);
            end
        end
        steady = 1'b0;
    endtask

    // cycle one slot through free and reuse, advancing its generation each round
    task automatic test_generation_advance();
        logic [SLOT_BITS-1:0] s;
        logic [GEN_BITS-1:0]  first_gen;
        send_req(REQ_ALLOC, '0, '0, $urandom);
        void'(pick_live_slot(s));
        first_gen = slot_gen[s];
        repeat (REUSE_ROUNDS) begin
            send_req(REQ_FREE, s, slot_gen[s], $urandom);
            send_req(REQ_ALLOC, SLOT_BITS'($urandom), GEN_BITS'($urandom), $urandom);
        end
        send_req(REQ_LOOKUP, s, first_gen, '0);
        send_req(REQ_LOOKUP, s, slot_gen[s], '0);
    endtask

    initial begin
        req_if.valid             = 1'b0;
        req_if.req_type          = REQ_ALLOC;
        req_if.slot_index        = '0;
        req_if.handle_generation = '0;
        req_if.ref_word          = '0;
        rsp_if.ready             = 1'b0;
        i_rst_n                  = 1'b0;
        steady                   = 1'b0;
        mismatch_count           = 0;
        for (int k = 0; k < SLOT_COUNT; k++) begin
            slot_alive[k] = 1'b0;
            slot_gen[k]   = '0;
        end
        free_head  = NSLOTS;
        high_water = '0;
        live_cnt   = '0;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_pool();
        test_handle_lifecycle();
        test_random_traffic(RANDOM_ITEMS);
        test_generation_advance();

        // drain outstanding results
        req_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("** generational_slot_allocator_top: PASSED **");
        else
            $display("** generational_slot_allocator_top: FAILED **");
        $finish;
    end

endmodule
